// ----- rtl/core/gfpc_pkg.sv -----
// Package for the ghost and floor point classifier.
// Holds widths, class and register codes, and the structs passed between modules.
// Depends on nothing; every other rtl/core file imports it.
`default_nettype none

package gfpc_pkg;

    // Field widths
    localparam int COORD_BITS = 16;
    localparam int NORM_BITS  = 16;
    localparam int THR_BITS   = 15;
    localparam int CIDX_BITS  = 3;
    localparam int CDATA_BITS = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS;

    // Ray and product widths
    localparam int RAY_W  = COORD_BITS + 1;
    localparam int PROD_W = RAY_W + NORM_BITS;
    localparam int DOT_W  = PROD_W + 2;
    localparam int D_W    = DOT_W;
    localparam int SQ_W   = 2 * RAY_W;
    localparam int R2_W   = SQ_W + 2;
    localparam int S2_W   = 2 * THR_BITS;

    // Split of the wide products into partial products
    localparam int D_LO_W = (D_W + 1) / 2;
    localparam int D_HI_W = D_W - D_LO_W;
    localparam int R_LO_W = (R2_W + 1) / 2;
    localparam int R_HI_W = R2_W - R_LO_W;
    localparam int HH_W   = 2 * D_HI_W;
    localparam int HL_W   = D_HI_W + D_LO_W;
    localparam int LL_W   = 2 * D_LO_W;
    localparam int SH_W   = S2_W + R_HI_W;
    localparam int SL_W   = S2_W + R_LO_W;
    localparam int D2_W   = 2 * D_W;
    localparam int RS_W   = S2_W + R2_W;
    localparam int WIDE_W = (D2_W > RS_W) ? D2_W : RS_W;

    // Magnitude compare widths for the floor test
    localparam int PMAG_W = COORD_BITS + 1;
    localparam int BAND_W = (PMAG_W > THR_BITS) ? PMAG_W : THR_BITS;
    localparam int NMAG_W = NORM_BITS + 1;

    // Stream word widths
    localparam int S_DATA_W = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CLASS_KEEP  = 2'd0,
        CLASS_GHOST = 2'd1,
        CLASS_FLOOR = 2'd2
    } class_t;

    typedef enum logic [CIDX_BITS-1:0] {
        IDX_GHOST_ENABLE  = 3'd0,
        IDX_FLOOR_ENABLE  = 3'd1,
        IDX_GHOST_SINE    = 3'd2,
        IDX_FLOOR_COSINE  = 3'd3,
        IDX_FLOOR_BAND    = 3'd4,
        IDX_SENSOR_X      = 3'd5,
        IDX_SENSOR_Y      = 3'd6,
        IDX_SENSOR_Z      = 3'd7
    } cfg_idx_t;

    localparam logic [THR_BITS-1:0] RST_GHOST_SINE   = 15'd2856;
    localparam logic [THR_BITS-1:0] RST_FLOOR_COSINE = 15'd28378;
    localparam logic [THR_BITS-1:0] RST_FLOOR_BAND   = 15'd25;

    typedef struct packed {
        logic                         ghost_enable;
        logic                         floor_enable;
        logic [THR_BITS-1:0]          ghost_sine_threshold;
        logic [S2_W-1:0]              ghost_sine_sq;
        logic [THR_BITS-1:0]          floor_cosine_threshold;
        logic [THR_BITS-1:0]          floor_half_band;
        logic signed [COORD_BITS-1:0] sensor_x;
        logic signed [COORD_BITS-1:0] sensor_y;
        logic signed [COORD_BITS-1:0] sensor_z;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [NORM_BITS-1:0]  norm_x;
        logic signed [NORM_BITS-1:0]  norm_y;
        logic signed [NORM_BITS-1:0]  norm_z;
    } point_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_z;
        logic                  ghost_en;
        logic                  floor_hit;
        logic [D_W-1:0]        dot_mag;
        logic [R2_W-1:0]       ray_sq;
    } geo_t;

    typedef struct packed {
        class_t                point_class;
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [COORD_BITS-1:0] out_z;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ghost_and_floor_point_classifier.sv -----
// Top level of the ghost and floor point classifier.
// Instantiates gfpc_cfg, gfpc_geom and gfpc_cmp; depends on gfpc_pkg.
//
//   channel   direction  handshake           payload
//   s_        in         s_tvalid/s_tready   s_tdata: point position and normal
//   m_        out        m_tvalid/m_tready   m_tuser: class, m_tdata: position
//   cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One point per cycle sustained while m_tready is high; a result passes the
// six register stages (ray, products, sums, partial products, wide sums,
// decision). Reset (aresetn low at a clock edge) empties the pipeline and
// loads the register defaults. A stall at m_ holds the last stage; empty
// stages upstream keep filling, so s_tready drops only when all six stages
// hold words. A sine threshold write acts via ghost_sine_reg and its square.
`default_nettype none

module ghost_and_floor_point_classifier (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z from bit 0 up
    input  wire logic [gfpc_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // out_x, out_y, out_z from bit 0 up
    output logic [gfpc_pkg::M_DATA_W-1:0]        m_tdata,
    // point_class
    output logic [1:0]                           m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gfpc_pkg::CIDX_BITS-1:0]  cfg_index,
    input  wire logic [gfpc_pkg::CDATA_BITS-1:0] cfg_data
);
    import gfpc_pkg::*;

    cfg_t   cfg;
    point_t point;
    geo_t   geo_item;
    res_t   res_item;
    logic   geo_valid, geo_ready;

    // Unpack the input word
    always_comb begin
        point.pos_x  = signed'(s_tdata[0*COORD_BITS +: COORD_BITS]);
        point.pos_y  = signed'(s_tdata[1*COORD_BITS +: COORD_BITS]);
        point.pos_z  = signed'(s_tdata[2*COORD_BITS +: COORD_BITS]);
        point.norm_x = signed'(s_tdata[3*COORD_BITS +: NORM_BITS]);
        point.norm_y = signed'(s_tdata[3*COORD_BITS+NORM_BITS +: NORM_BITS]);
        point.norm_z = signed'(s_tdata[3*COORD_BITS+2*NORM_BITS +: NORM_BITS]);
    end

    gfpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gfpc_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_point  (point),
        .out_valid (geo_valid),
        .out_ready (geo_ready),
        .out_item  (geo_item)
    );

    gfpc_cmp u_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .in_item   (geo_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (res_item)
    );

    // Pack the result word
    always_comb begin
        m_tdata = '0;
        m_tdata[0*COORD_BITS +: COORD_BITS] = res_item.out_x;
        m_tdata[1*COORD_BITS +: COORD_BITS] = res_item.out_y;
        m_tdata[2*COORD_BITS +: COORD_BITS] = res_item.out_z;
        m_tuser = res_item.point_class;
    end

    // A ready sink lets every stage advance, so the input is open
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A ghost enable write lands in the register file
    a_cfg_ghost_en: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cfg_valid && cfg_ready && cfg_index == IDX_GHOST_ENABLE)
        |=> cfg.ghost_enable == $past(cfg_data[0]))
        else $error("ghost enable write lost");

endmodule

`default_nettype wire

// ----- rtl/core/gfpc_cfg.sv -----
// Configuration register file of the point classifier.
// Takes index/data writes and keeps the squared sine threshold registered.
// Depends on gfpc_pkg.
`default_nettype none

module gfpc_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gfpc_pkg::CIDX_BITS-1:0]  cfg_index,
    input  wire logic [gfpc_pkg::CDATA_BITS-1:0] cfg_data,
    output gfpc_pkg::cfg_t                       cfg
);
    import gfpc_pkg::*;

    logic                  ghost_enable_reg;
    logic                  floor_enable_reg;
    logic [THR_BITS-1:0]   ghost_sine_reg;
    logic [S2_W-1:0]       ghost_sine_sq_reg;
    logic [THR_BITS-1:0]   floor_cosine_reg;
    logic [THR_BITS-1:0]   floor_band_reg;
    logic [COORD_BITS-1:0] sensor_x_reg;
    logic [COORD_BITS-1:0] sensor_y_reg;
    logic [COORD_BITS-1:0] sensor_z_reg;
    logic                  cfg_wr;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // Decode and store one register per write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ghost_enable_reg <= 1'b1;
            floor_enable_reg <= 1'b0;
            ghost_sine_reg   <= RST_GHOST_SINE;
            floor_cosine_reg <= RST_FLOOR_COSINE;
            floor_band_reg   <= RST_FLOOR_BAND;
            sensor_x_reg     <= '0;
            sensor_y_reg     <= '0;
            sensor_z_reg     <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx_t'(cfg_index))
                IDX_GHOST_ENABLE: ghost_enable_reg <= cfg_data[0];
                IDX_FLOOR_ENABLE: floor_enable_reg <= cfg_data[0];
                IDX_GHOST_SINE:   ghost_sine_reg   <= cfg_data[THR_BITS-1:0];
                IDX_FLOOR_COSINE: floor_cosine_reg <= cfg_data[THR_BITS-1:0];
                IDX_FLOOR_BAND:   floor_band_reg   <= cfg_data[THR_BITS-1:0];
                IDX_SENSOR_X:     sensor_x_reg     <= cfg_data[COORD_BITS-1:0];
                IDX_SENSOR_Y:     sensor_y_reg     <= cfg_data[COORD_BITS-1:0];
                IDX_SENSOR_Z:     sensor_z_reg     <= cfg_data[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register the square of the stored sine threshold
    always_ff @(posedge aclk) begin
        ghost_sine_sq_reg <= ghost_sine_reg * ghost_sine_reg;
    end

    always_comb begin
        cfg.ghost_enable           = ghost_enable_reg;
        cfg.floor_enable           = floor_enable_reg;
        cfg.ghost_sine_threshold   = ghost_sine_reg;
        cfg.ghost_sine_sq          = ghost_sine_sq_reg;
        cfg.floor_cosine_threshold = floor_cosine_reg;
        cfg.floor_half_band        = floor_band_reg;
        cfg.sensor_x               = signed'(sensor_x_reg);
        cfg.sensor_y               = signed'(sensor_y_reg);
        cfg.sensor_z               = signed'(sensor_z_reg);
    end

endmodule

`default_nettype wire

// ----- rtl/core/gfpc_geom.sv -----
// Geometry stages of the point classifier: ray, products, dot and ray length.
// Three register stages with valid bits and a per-stage ready chain.
// Depends on gfpc_pkg.
`default_nettype none

module gfpc_geom (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire gfpc_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire gfpc_pkg::point_t in_point,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output gfpc_pkg::geo_t       out_item
);
    import gfpc_pkg::*;

    // Stage 1: ray and floor test
    logic                     v1_reg;
    logic signed [RAY_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [NORM_BITS-1:0] nx_reg, ny_reg, nz_reg;
    logic [COORD_BITS-1:0]    p1x_reg, p1y_reg, p1z_reg;
    logic                     g1_reg, f1_reg;
    // Stage 2: products
    logic                     v2_reg;
    logic signed [PROD_W-1:0] dpx_reg, dpy_reg, dpz_reg;
    logic signed [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [COORD_BITS-1:0]    p2x_reg, p2y_reg, p2z_reg;
    logic                     g2_reg, f2_reg;
    // Stage 3: sums
    logic                     v3_reg;
    logic [D_W-1:0]           d_reg;
    logic [R2_W-1:0]          r2_reg;
    logic [COORD_BITS-1:0]    p3x_reg, p3y_reg, p3z_reg;
    logic                     g3_reg, f3_reg;

    logic                     en1, en2, en3;
    logic [PMAG_W-1:0]        pz_mag;
    logic [NMAG_W-1:0]        nz_mag;
    logic                     floor_next;
    logic signed [DOT_W-1:0]  dot_next;
    logic [D_W-1:0]           d_next;
    logic [R2_W-1:0]          r2_next;
    logic signed [PROD_W-1:0] dpx_next, dpy_next, dpz_next;
    logic signed [SQ_W-1:0]   sqx_next, sqy_next, sqz_next;

    // Advance a stage when it is empty or its successor advances
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Floor band and tilt test on the incoming word
    always_comb begin
        pz_mag = in_point.pos_z[COORD_BITS-1]
               ? PMAG_W'(-PMAG_W'(in_point.pos_z)) : PMAG_W'(in_point.pos_z);
        nz_mag = in_point.norm_z[NORM_BITS-1]
               ? NMAG_W'(-NMAG_W'(in_point.norm_z)) : NMAG_W'(in_point.norm_z);
        floor_next = cfg.floor_enable
                   && (BAND_W'(pz_mag) < BAND_W'(cfg.floor_half_band))
                   && (nz_mag >= NMAG_W'(cfg.floor_cosine_threshold));
    end

    // Products of ray with normal and with itself
    always_comb begin
        dpx_next = rx_reg * nx_reg;
        dpy_next = ry_reg * ny_reg;
        dpz_next = rz_reg * nz_reg;
        sqx_next = rx_reg * rx_reg;
        sqy_next = ry_reg * ry_reg;
        sqz_next = rz_reg * rz_reg;
    end

    // Dot product magnitude and squared ray length
    always_comb begin
        dot_next = DOT_W'(dpx_reg) + DOT_W'(dpy_reg) + DOT_W'(dpz_reg);
        d_next   = dot_next[DOT_W-1] ? unsigned'(-dot_next) : unsigned'(dot_next);
        r2_next  = unsigned'(R2_W'(sqx_reg) + R2_W'(sqy_reg) + R2_W'(sqz_reg));
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Payload, held while a stage stalls
    always_ff @(posedge aclk) begin
        if (en1) begin
            rx_reg  <= RAY_W'(in_point.pos_x) - RAY_W'(cfg.sensor_x);
            ry_reg  <= RAY_W'(in_point.pos_y) - RAY_W'(cfg.sensor_y);
            rz_reg  <= RAY_W'(in_point.pos_z) - RAY_W'(cfg.sensor_z);
            nx_reg  <= in_point.norm_x;
            ny_reg  <= in_point.norm_y;
            nz_reg  <= in_point.norm_z;
            p1x_reg <= in_point.pos_x;
            p1y_reg <= in_point.pos_y;
            p1z_reg <= in_point.pos_z;
            g1_reg  <= cfg.ghost_enable;
            f1_reg  <= floor_next;
        end
        if (en2) begin
            dpx_reg <= dpx_next;
            dpy_reg <= dpy_next;
            dpz_reg <= dpz_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sqz_reg <= sqz_next;
            p2x_reg <= p1x_reg;
            p2y_reg <= p1y_reg;
            p2z_reg <= p1z_reg;
            g2_reg  <= g1_reg;
            f2_reg  <= f1_reg;
        end
        if (en3) begin
            d_reg   <= d_next;
            r2_reg  <= r2_next;
            p3x_reg <= p2x_reg;
            p3y_reg <= p2y_reg;
            p3z_reg <= p2z_reg;
            g3_reg  <= g2_reg;
            f3_reg  <= f2_reg;
        end
    end

    assign out_valid = v3_reg;

    always_comb begin
        out_item.pos_x     = p3x_reg;
        out_item.pos_y     = p3y_reg;
        out_item.pos_z     = p3z_reg;
        out_item.ghost_en  = g3_reg;
        out_item.floor_hit = f3_reg;
        out_item.dot_mag   = d_reg;
        out_item.ray_sq    = r2_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/gfpc_cmp.sv -----
// Wide compare stages of the point classifier: dot^2 against sine^2 * |ray|^2.
// Partial products, their sums, then the class decision in the output register.
// Depends on gfpc_pkg.
`default_nettype none

module gfpc_cmp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire gfpc_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire gfpc_pkg::geo_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output gfpc_pkg::res_t      out_item
);
    import gfpc_pkg::*;

    // Stage 4: partial products
    logic                  v4_reg;
    logic [HH_W-1:0]       hh_reg;
    logic [HL_W-1:0]       hl_reg;
    logic [LL_W-1:0]       ll_reg;
    logic [SH_W-1:0]       sh_reg;
    logic [SL_W-1:0]       sl_reg;
    logic [COORD_BITS-1:0] p4x_reg, p4y_reg, p4z_reg;
    logic                  g4_reg, f4_reg;
    // Stage 5: full products
    logic                  v5_reg;
    logic [D2_W-1:0]       d2_reg;
    logic [RS_W-1:0]       rs_reg;
    logic [COORD_BITS-1:0] p5x_reg, p5y_reg, p5z_reg;
    logic                  g5_reg, f5_reg;
    // Stage 6: result
    logic                  v6_reg;
    class_t                class_reg;
    logic [COORD_BITS-1:0] p6x_reg, p6y_reg, p6z_reg;

    logic                  en4, en5, en6;
    logic [D_HI_W-1:0]     dh;
    logic [D_LO_W-1:0]     dl;
    logic [R_HI_W-1:0]     rh;
    logic [R_LO_W-1:0]     rl;
    logic [D2_W-1:0]       d2_next;
    logic [RS_W-1:0]       rs_next;
    logic                  ghost_hit;
    class_t                class_next;

    assign en6      = !v6_reg || out_ready;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    // Split both wide operands into halves
    assign dh = in_item.dot_mag[D_W-1:D_LO_W];
    assign dl = in_item.dot_mag[D_LO_W-1:0];
    assign rh = in_item.ray_sq[R2_W-1:R_LO_W];
    assign rl = in_item.ray_sq[R_LO_W-1:0];

    // Recombine partial products
    always_comb begin
        d2_next = (D2_W'(hh_reg) << (2 * D_LO_W))
                + (D2_W'(hl_reg) << (D_LO_W + 1))
                + D2_W'(ll_reg);
        rs_next = (RS_W'(sh_reg) << R_LO_W) + RS_W'(sl_reg);
    end

    // Ghost, if enabled, unless the dot term strictly wins; floor only for non-ghosts
    always_comb begin
        ghost_hit = g5_reg && !(WIDE_W'(d2_reg) > WIDE_W'(rs_reg));
        if (ghost_hit) begin
            class_next = CLASS_GHOST;
        end else if (f5_reg) begin
            class_next = CLASS_FLOOR;
        end else begin
            class_next = CLASS_KEEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en4) v4_reg <= in_valid;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            hh_reg  <= HH_W'(dh) * HH_W'(dh);
            hl_reg  <= HL_W'(dh) * HL_W'(dl);
            ll_reg  <= LL_W'(dl) * LL_W'(dl);
            sh_reg  <= SH_W'(cfg.ghost_sine_sq) * SH_W'(rh);
            sl_reg  <= SL_W'(cfg.ghost_sine_sq) * SL_W'(rl);
            p4x_reg <= in_item.pos_x;
            p4y_reg <= in_item.pos_y;
            p4z_reg <= in_item.pos_z;
            g4_reg  <= in_item.ghost_en;
            f4_reg  <= in_item.floor_hit;
        end
        if (en5) begin
            d2_reg  <= d2_next;
            rs_reg  <= rs_next;
            p5x_reg <= p4x_reg;
            p5y_reg <= p4y_reg;
            p5z_reg <= p4z_reg;
            g5_reg  <= g4_reg;
            f5_reg  <= f4_reg;
        end
        if (en6) begin
            class_reg <= class_next;
            p6x_reg   <= p5x_reg;
            p6y_reg   <= p5y_reg;
            p6z_reg   <= p5z_reg;
        end
    end

    assign out_valid = v6_reg;

    always_comb begin
        out_item.point_class = class_reg;
        out_item.out_x       = p6x_reg;
        out_item.out_y       = p6y_reg;
        out_item.out_z       = p6z_reg;
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ghost_and_floor_point_classifier: directed table, then random phases.
// Predicts class and position echo per point in-line; depends on gfpc_pkg and the rtl/core sources.
module tb_top;
    import gfpc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int PIPE_DEPTH    = 6;
    localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH;
    localparam int RAND_PHASES   = 11;
    localparam int PHASE_POINTS  = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 50;

    localparam logic signed [15:0] C_MAX = 16'sh7FFF;
    localparam logic signed [15:0] C_MIN = 16'sh8000;

    typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_KNOWN} row_kind_t;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_SLOW} rdy_mode_t;

    typedef struct packed {
        row_kind_t                kind;
        cfg_idx_t                 idx;
        logic [CDATA_BITS-1:0]    val;
        logic signed [15:0]       px, py, pz, nx, ny, nz;
        class_t                   cls;
    } dir_row_t;

    localparam int N_DIR = 37;

    // Directed table: register writes, extremes and the corner cases of both tests
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // point at the sensor is ghost with the reset settings
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, C_MAX, CLASS_GHOST},
        // ray along the normal, ray across the normal
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd1000, 16'sd0, 16'sd0,
          C_MAX, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd1000, 16'sd0, 16'sd0,
          16'sd0, C_MAX, 16'sd0, CLASS_GHOST},
        '{ROW_PREDICT, IDX_GHOST_ENABLE, 16'd0, C_MAX, C_MAX, C_MAX,
          C_MIN, C_MIN, C_MIN, CLASS_KEEP},
        '{ROW_PREDICT, IDX_GHOST_ENABLE, 16'd0, C_MIN, C_MIN, C_MIN,
          C_MAX, C_MAX, C_MAX, CLASS_KEEP},
        '{ROW_PREDICT, IDX_GHOST_ENABLE, 16'd0, C_MIN, C_MAX, 16'sd0,
          C_MIN, 16'sd0, 16'sd0, CLASS_KEEP},
        // tiny normal used as given
        '{ROW_PREDICT, IDX_GHOST_ENABLE, 16'd0, 16'sd100, 16'sd200, 16'sd300,
          16'sd1, 16'sd1, 16'sd1, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd5, 16'sd5, 16'sd5,
          16'sd0, 16'sd0, 16'sd0, CLASS_GHOST},
        // floor test on; ghost still wins
        '{ROW_WRITE,   IDX_FLOOR_ENABLE, 16'd1, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, C_MAX, CLASS_GHOST},
        // band edge is strict, cosine edge is inclusive, -32768 is full scale
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd10, 16'sd20, 16'sd24,
          16'sd0, 16'sd0, C_MAX, CLASS_FLOOR},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd10, 16'sd20, 16'sd25,
          16'sd0, 16'sd0, C_MAX, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd10, 16'sd20, -16'sd24,
          16'sd0, 16'sd0, C_MIN, CLASS_FLOOR},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd10, 16'sd20, -16'sd24,
          16'sd0, 16'sd0, 16'sd28378, CLASS_FLOOR},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd10, 16'sd20, -16'sd24,
          16'sd0, 16'sd0, 16'sd28377, CLASS_KEEP},
        // ghost test off
        '{ROW_WRITE,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, C_MAX, CLASS_FLOOR},
        // both tests off
        '{ROW_WRITE,   IDX_FLOOR_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, C_MAX, CLASS_KEEP},
        // zero sine threshold: only a zero dot product (perpendicular ray) is ghost
        '{ROW_WRITE,   IDX_GHOST_ENABLE, 16'd1, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_WRITE,   IDX_GHOST_SINE,   16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd1000, 16'sd0, 16'sd0,
          16'sd1, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd1000, 16'sd0, 16'sd0,
          16'sd0, 16'sd1, 16'sd0, CLASS_GHOST},
        // extreme thresholds and sensor corners
        '{ROW_WRITE,   IDX_GHOST_SINE,   16'd32767, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_WRITE,   IDX_FLOOR_COSINE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_WRITE,   IDX_FLOOR_BAND,   16'd32767, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_WRITE,   IDX_SENSOR_X,     16'h8000, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_WRITE,   IDX_SENSOR_Y,     16'h7FFF, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_WRITE,   IDX_SENSOR_Z,     16'h8000, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_PREDICT, IDX_GHOST_ENABLE, 16'd0, C_MAX, C_MIN, C_MAX,
          C_MAX, C_MIN, C_MAX, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, C_MIN, C_MAX, C_MIN,
          C_MAX, 16'sd0, 16'sd0, CLASS_GHOST},
        '{ROW_PREDICT, IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, C_MAX, CLASS_KEEP},
        // floor only, widest band, zero cosine
        '{ROW_WRITE,   IDX_FLOOR_ENABLE, 16'd1, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_WRITE,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd0, 16'sd0, -16'sd32766,
          16'sd0, 16'sd0, 16'sd0, CLASS_FLOOR},
        '{ROW_KNOWN,   IDX_GHOST_ENABLE, 16'd0, 16'sd100, 16'sd100, C_MIN,
          16'sd0, 16'sd0, 16'sd0, CLASS_KEEP}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CIDX_BITS-1:0]  cfg_index = '0;
    logic [CDATA_BITS-1:0] cfg_data  = '0;

    // Shadow of the register file as the block should see it
    logic                         cur_ghost_en = 1'b1;
    logic                         cur_floor_en = 1'b0;
    logic [THR_BITS-1:0]          cur_sine     = RST_GHOST_SINE;
    logic [THR_BITS-1:0]          cur_cosine   = RST_FLOOR_COSINE;
    logic [THR_BITS-1:0]          cur_band     = RST_FLOOR_BAND;
    logic signed [COORD_BITS-1:0] cur_sx       = '0;
    logic signed [COORD_BITS-1:0] cur_sy       = '0;
    logic signed [COORD_BITS-1:0] cur_sz       = '0;

    res_t        labels_due [$];
    int          err_cnt   = 0;
    int unsigned cycle_cnt = 0;
    int          burst_left = 0;
    int          gap_max    = 0;
    rdy_mode_t   rdy_mode   = RDY_ALWAYS;

    ghost_and_floor_point_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** ghost_and_floor_point_classifier: FAILED **");
            $finish;
        end
    end

    // Ghost test without square roots, then the floor band and tilt test
    function automatic class_t classify_point(input point_t p);
        longint rx, ry, rz, dot_v, dot_mag, ray_sq, pz_mag, nz_mag;
        logic [127:0] lhs, rhs;
        logic ghost;
        rx      = longint'(p.pos_x) - longint'(cur_sx);
        ry      = longint'(p.pos_y) - longint'(cur_sy);
        rz      = longint'(p.pos_z) - longint'(cur_sz);
        dot_v   = rx * longint'(p.norm_x) + ry * longint'(p.norm_y) + rz * longint'(p.norm_z);
        dot_mag = (dot_v < 0) ? -dot_v : dot_v;
        ray_sq  = rx * rx + ry * ry + rz * rz;
        lhs     = 128'(dot_mag) * 128'(dot_mag);
        rhs     = 128'(longint'(cur_sine) * longint'(cur_sine)) * 128'(ray_sq);
        ghost   = !(lhs > rhs);
        pz_mag  = longint'(p.pos_z);
        nz_mag  = longint'(p.norm_z);
        if (pz_mag < 0) pz_mag = -pz_mag;
        if (nz_mag < 0) nz_mag = -nz_mag;
        if (cur_ghost_en && ghost)
            return CLASS_GHOST;
        if (cur_floor_en && pz_mag < longint'(cur_band) && nz_mag >= longint'(cur_cosine))
            return CLASS_FLOOR;
        return CLASS_KEEP;
    endfunction

    function automatic res_t labelled_point(input point_t p);
        res_t r;
        r.point_class = classify_point(p);
        r.out_x       = p.pos_x;
        r.out_y       = p.pos_y;
        r.out_z       = p.pos_z;
        return r;
    endfunction

    function automatic int rand_in(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [15:0] fit16(input int v);
        if (v > 32767) return C_MAX;
        if (v < -32768) return C_MIN;
        return 16'(v);
    endfunction

    function automatic logic [THR_BITS-1:0] pick_thr(input int typical, input int lo,
                                                     input int hi);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return THR_BITS'(typical);
            3:       return THR_BITS'(rand_in(lo, hi));
            default: return THR_BITS'($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sensor();
        case ($urandom_range(0, 5))
            0:       return C_MIN;
            1:       return C_MAX;
            default: return fit16(rand_in(-2000, 2000));
        endcase
    endfunction

    // Mostly shaped points (floor candidates, grazing rays, near the sensor), some noise
    function automatic point_t make_point();
        point_t p;
        int rx, ry, rz, band, nz_abs;
        case ($urandom_range(0, 9))
            0, 1: p = point_t'({$urandom(), $urandom(), $urandom()});
            2, 3, 4: begin
                band     = int'(cur_band) + 2;
                nz_abs   = rand_in(int'(cur_cosine) - 300, 32768);
                p.pos_x  = fit16(rand_in(-5000, 5000));
                p.pos_y  = fit16(rand_in(-5000, 5000));
                p.pos_z  = fit16(rand_in(-band, band));
                p.norm_x = fit16(rand_in(-3000, 3000));
                p.norm_y = fit16(rand_in(-3000, 3000));
                p.norm_z = fit16(($urandom_range(0, 1) != 0) ? -nz_abs : nz_abs);
            end
            5, 6, 7: begin
                rx       = rand_in(-1000, 1000);
                ry       = rand_in(-1000, 1000);
                rz       = rand_in(-1000, 1000);
                p.pos_x  = fit16(int'(cur_sx) + rx);
                p.pos_y  = fit16(int'(cur_sy) + ry);
                p.pos_z  = fit16(int'(cur_sz) + rz);
                p.norm_x = fit16(-ry * 30 + rand_in(-2000, 2000));
                p.norm_y = fit16(rx * 30 + rand_in(-2000, 2000));
                p.norm_z = fit16(rand_in(-3000, 3000));
            end
            default: begin
                p.pos_x  = fit16(int'(cur_sx) + rand_in(-2, 2));
                p.pos_y  = fit16(int'(cur_sy) + rand_in(-2, 2));
                p.pos_z  = fit16(int'(cur_sz) + rand_in(-2, 2));
                p.norm_x = 16'($urandom());
                p.norm_y = 16'($urandom());
                p.norm_z = 16'($urandom());
            end
        endcase
        return p;
    endfunction

    // Hold one point word on s_ until taken, idling between bursts
    task automatic send_point(input point_t p, input res_t want);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata  <= {p.norm_z, p.norm_y, p.norm_x, p.pos_z, p.pos_y, p.pos_x};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        labels_due.insert(labels_due.size(), want);
    endtask

    // Write one register and track it; cfg_valid stays high for the next write
    task automatic write_reg(input cfg_idx_t idx, input logic [CDATA_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            IDX_GHOST_ENABLE: cur_ghost_en = val[0];
            IDX_FLOOR_ENABLE: cur_floor_en = val[0];
            IDX_GHOST_SINE:   cur_sine     = val[THR_BITS-1:0];
            IDX_FLOOR_COSINE: cur_cosine   = val[THR_BITS-1:0];
            IDX_FLOOR_BAND:   cur_band     = val[THR_BITS-1:0];
            IDX_SENSOR_X:     cur_sx       = val[COORD_BITS-1:0];
            IDX_SENSOR_Y:     cur_sy       = val[COORD_BITS-1:0];
            IDX_SENSOR_Z:     cur_sz       = val[COORD_BITS-1:0];
            default: ;
        endcase
    endtask

    // Drop valid, wait for every label, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (labels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Load all registers for one random phase; phases 1 and 2 take the extremes
    task automatic configure_phase(input int ph);
        logic                g_en, f_en;
        logic [THR_BITS-1:0] sine, cosv, band;
        logic signed [15:0]  sx, sy, sz;
        case (ph)
            1: begin
                g_en = 1'b1; f_en = 1'b1;
                sine = '0; cosv = '0; band = '1;
                sx = C_MIN; sy = C_MIN; sz = C_MIN;
            end
            2: begin
                g_en = 1'b1; f_en = 1'b1;
                sine = '1; cosv = '1; band = '0;
                sx = C_MAX; sy = C_MAX; sz = C_MAX;
            end
            default: begin
                g_en = ($urandom_range(0, 3) != 0);
                f_en = ($urandom_range(0, 2) != 0);
                sine = pick_thr(int'(RST_GHOST_SINE), 0, 8000);
                cosv = pick_thr(int'(RST_FLOOR_COSINE), 20000, 32767);
                band = pick_thr(int'(RST_FLOOR_BAND), 0, 300);
                sx   = pick_sensor();
                sy   = pick_sensor();
                sz   = pick_sensor();
            end
        endcase
        write_reg(IDX_GHOST_ENABLE, CDATA_BITS'(g_en));
        write_reg(IDX_FLOOR_ENABLE, CDATA_BITS'(f_en));
        write_reg(IDX_GHOST_SINE,   CDATA_BITS'(sine));
        write_reg(IDX_FLOOR_COSINE, CDATA_BITS'(cosv));
        write_reg(IDX_FLOOR_BAND,   CDATA_BITS'(band));
        write_reg(IDX_SENSOR_X,     sx);
        write_reg(IDX_SENSOR_Y,     sy);
        write_reg(IDX_SENSOR_Z,     sz);
        cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        case (rdy_mode)
            RDY_ALWAYS:   m_tready <= 1'b1;
            RDY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: m_tready <= ((cycle_cnt % 11) < 6);
            default:      if ($urandom_range(0, 9) == 0) m_tready <= ~m_tready;
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] actual,
                               input logic [31:0] want);
        if (actual !== want) begin
            if (err_cnt < MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, actual);
            err_cnt++;
        end
    endtask

    // Compare each result word with the oldest pending label
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (labels_due.size() == 0) begin
                if (err_cnt < MAX_REPORTS)
                    $display("%0t: unexpected word, expected none actual class %0d pos %h",
                             $time, m_tuser, m_tdata);
                err_cnt++;
            end else begin
                want = labels_due.pop_front();
                check_field("point_class", m_tuser, want.point_class);
                check_field("out_x", m_tdata[COORD_BITS-1:0], want.out_x);
                check_field("out_y", m_tdata[2*COORD_BITS-1:COORD_BITS], want.out_y);
                check_field("out_z", m_tdata[3*COORD_BITS-1:2*COORD_BITS], want.out_z);
            end
        end
    end

    initial begin
        point_t   p;
        res_t     want;
        dir_row_t row;
        logic     prev_write;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        gap_max    = 2;
        rdy_mode   = RDY_RANDOM;
        prev_write = 1'b0;
        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                if (!prev_write) settle();
                write_reg(row.idx, row.val);
                prev_write = 1'b1;
            end else begin
                if (prev_write) cfg_valid <= 1'b0;
                prev_write = 1'b0;
                p.pos_x  = row.px;
                p.pos_y  = row.py;
                p.pos_z  = row.pz;
                p.norm_x = row.nx;
                p.norm_y = row.ny;
                p.norm_z = row.nz;
                want = labelled_point(p);
                if (row.kind == ROW_KNOWN) want.point_class = row.cls;
                send_point(p, want);
            end
        end

        // Random phases, each with fresh registers; idling and back-pressure vary by phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            configure_phase(ph);
            gap_max  = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 12);
            rdy_mode = rdy_mode_t'(ph % 4);
            for (int k = 0; k < PHASE_POINTS; k++) begin
                p = make_point();
                send_point(p, labelled_point(p));
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("** ghost_and_floor_point_classifier: PASSED **");
        end else begin
            $display("** ghost_and_floor_point_classifier: FAILED **");
        end
        $finish;
    end

endmodule
